FILE: sv/sic_pkg.sv
// ---------------------------------------------------------------------------
// sic_pkg
// types and codes shared by the segment intersection classify pipeline
// ---------------------------------------------------------------------------
package sic_pkg;

  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_REGULAR = 3'd1,
    KIND_A_ON_PQ = 3'd2,
    KIND_B_ON_PQ = 3'd3,
    KIND_EDGE    = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    LOC_A,
    LOC_B,
    LOC_IN,
    LOC_OUT,
    LOC_LEFT,
    LOC_RIGHT
  } loc_e;

  // end point coincidences between the two segments
  typedef struct packed {
    logic pa;  // p equals a
    logic qa;  // q equals a
    logic pb;  // p equals b
    logic qb;  // q equals b
  } eq_t;

  // sideband that follows an item through the divider
  typedef struct packed {
    kind_e kind;
    logic  neg_x;
    logic  neg_y;
  } ctrl_t;

  // positions in the cross product and distance vectors
  localparam int unsigned CR_DEN  = 0;
  localparam int unsigned CR_NUM  = 1;
  localparam int unsigned CR_DETP = 2;
  localparam int unsigned CR_DETQ = 3;
  localparam int unsigned CR_DETB = 4;
  localparam int unsigned CR_K4   = 5;

  localparam int unsigned DS_AB = 0;
  localparam int unsigned DS_PQ = 1;
  localparam int unsigned DS_PA = 2;
  localparam int unsigned DS_QA = 3;
  localparam int unsigned DS_BP = 4;
  localparam int unsigned DS_BQ = 5;

endpackage

FILE: sv/sic_front.sv
// ---------------------------------------------------------------------------
// sic_front
// differences, products and cross / squared distance sums (three stages)
// ---------------------------------------------------------------------------
module sic_front #(
  parameter int CB = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  logic signed [CB-1:0]    ax_i,
  input  logic signed [CB-1:0]    ay_i,
  input  logic signed [CB-1:0]    bx_i,
  input  logic signed [CB-1:0]    by_i,
  input  logic signed [CB-1:0]    px_i,
  input  logic signed [CB-1:0]    py_i,
  input  logic signed [CB-1:0]    qx_i,
  input  logic signed [CB-1:0]    qy_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output sic_pkg::eq_t            eq_o,
  output logic signed [CB-1:0]    ax_o,
  output logic signed [CB-1:0]    ay_o,
  output logic signed [CB:0]      abx_o,
  output logic signed [CB:0]      aby_o,
  output logic signed [2*CB+1:0]  cr_o [6],
  output logic [2*CB+1:0]         ds_o [6]
);
  import sic_pkg::*;

  localparam int DW = CB + 1;
  localparam int XW = 2 * DW;

  // difference slots
  localparam int ABX = 0, ABY = 1, PQX = 2, PQY = 3, PAX = 4, PAY = 5;
  localparam int QAX = 6, QAY = 7, BPX = 8, BPY = 9, BQX = 10, BQY = 11;

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  logic signed [DW-1:0] d1_q [12];
  logic signed [DW-1:0] d2_q [2];
  logic signed [DW-1:0] d3_q [2];
  logic signed [CB-1:0] a1_q [2];
  logic signed [CB-1:0] a2_q [2];
  logic signed [CB-1:0] a3_q [2];
  eq_t                  eq1_q, eq2_q, eq3_q;
  logic signed [XW-1:0] c2_q [12];
  logic signed [XW-1:0] s2_q [12];
  logic signed [XW-1:0] cr3_q [6];
  logic [XW-1:0]        ds3_q [6];

  assign rdy3    = !v3_q || ready_i;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // stage 1: coordinate differences and end point compares
  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) begin
      d1_q[ABX] <= DW'(bx_i) - DW'(ax_i);
      d1_q[ABY] <= DW'(by_i) - DW'(ay_i);
      d1_q[PQX] <= DW'(qx_i) - DW'(px_i);
      d1_q[PQY] <= DW'(qy_i) - DW'(py_i);
      d1_q[PAX] <= DW'(px_i) - DW'(ax_i);
      d1_q[PAY] <= DW'(py_i) - DW'(ay_i);
      d1_q[QAX] <= DW'(qx_i) - DW'(ax_i);
      d1_q[QAY] <= DW'(qy_i) - DW'(ay_i);
      d1_q[BPX] <= DW'(bx_i) - DW'(px_i);
      d1_q[BPY] <= DW'(by_i) - DW'(py_i);
      d1_q[BQX] <= DW'(bx_i) - DW'(qx_i);
      d1_q[BQY] <= DW'(by_i) - DW'(qy_i);
      eq1_q.pa  <= (px_i == ax_i) && (py_i == ay_i);
      eq1_q.qa  <= (qx_i == ax_i) && (qy_i == ay_i);
      eq1_q.pb  <= (px_i == bx_i) && (py_i == by_i);
      eq1_q.qb  <= (qx_i == bx_i) && (qy_i == by_i);
      a1_q[0]   <= ax_i;
      a1_q[1]   <= ay_i;
    end
  end

  // stage 2: products, one multiplier each
  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      c2_q[0]  <= d1_q[ABX] * d1_q[PQY];
      c2_q[1]  <= d1_q[ABY] * d1_q[PQX];
      c2_q[2]  <= d1_q[PAX] * d1_q[PQY];
      c2_q[3]  <= d1_q[PAY] * d1_q[PQX];
      c2_q[4]  <= d1_q[ABX] * d1_q[PAY];
      c2_q[5]  <= d1_q[ABY] * d1_q[PAX];
      c2_q[6]  <= d1_q[ABX] * d1_q[QAY];
      c2_q[7]  <= d1_q[ABY] * d1_q[QAX];
      c2_q[8]  <= d1_q[PQX] * d1_q[BPY];
      c2_q[9]  <= d1_q[PQY] * d1_q[BPX];
      c2_q[10] <= d1_q[PAX] * d1_q[QAY];
      c2_q[11] <= d1_q[PAY] * d1_q[QAX];
      for (int i = 0; i < 12; i++) begin
        s2_q[i] <= d1_q[i] * d1_q[i];
      end
      d2_q[0] <= d1_q[ABX];
      d2_q[1] <= d1_q[ABY];
      a2_q    <= a1_q;
      eq2_q   <= eq1_q;
    end
  end

  // stage 3: cross products and squared distances
  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      for (int k = 0; k < 6; k++) begin
        cr3_q[k] <= c2_q[2*k] - c2_q[2*k+1];
        ds3_q[k] <= $unsigned(s2_q[2*k]) + $unsigned(s2_q[2*k+1]);
      end
      d3_q  <= d2_q;
      a3_q  <= a2_q;
      eq3_q <= eq2_q;
    end
  end

  assign valid_o = v3_q;
  assign eq_o    = eq3_q;
  assign ax_o    = a3_q[0];
  assign ay_o    = a3_q[1];
  assign abx_o   = d3_q[0];
  assign aby_o   = d3_q[1];
  assign cr_o    = cr3_q;
  assign ds_o    = ds3_q;

endmodule

FILE: sv/sic_classify.sv
// ---------------------------------------------------------------------------
// sic_classify
// point placement, kind decision and dividend products (two stages)
// ---------------------------------------------------------------------------
module sic_classify #(
  parameter int CB = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  sic_pkg::eq_t              eq_i,
  input  logic signed [CB-1:0]      ax_i,
  input  logic signed [CB-1:0]      ay_i,
  input  logic signed [CB:0]        abx_i,
  input  logic signed [CB:0]        aby_i,
  input  logic signed [2*CB+1:0]    cr_i [6],
  input  logic [2*CB+1:0]           ds_i [6],
  output logic                      valid_o,
  input  logic                      ready_i,
  output sic_pkg::ctrl_t            ctrl_o,
  output logic signed [CB-1:0]      ax_o,
  output logic signed [CB-1:0]      ay_o,
  output logic [2*CB+1:0]           ud_o,
  output logic [3*CB+2:0]           prod_x_o,
  output logic [3*CB+2:0]           prod_y_o
);
  import sic_pkg::*;

  localparam int MW = CB + 1;
  localparam int NW = 2 * CB + 2;
  localparam int PW = MW + NW;

  function automatic loc_e locate(input logic is_a, input logic is_b,
                                  input logic signed [NW-1:0] det,
                                  input logic [NW-1:0] d0, input logic [NW-1:0] d1,
                                  input logic [NW-1:0] len);
    loc_e r;
    if (is_a) r = LOC_A;
    else if (is_b) r = LOC_B;
    else if (det == '0) r = ((d0 < len) && (d1 < len)) ? LOC_IN : LOC_OUT;
    else r = det[NW-1] ? LOC_RIGHT : LOC_LEFT;
    return r;
  endfunction

  function automatic logic same_side(input loc_e l1, input loc_e l2);
    return (l1 == l2) && ((l1 == LOC_LEFT) || (l1 == LOC_RIGHT));
  endfunction

  function automatic logic [NW-1:0] mag(input logic signed [NW-1:0] v);
    return v[NW-1] ? NW'(-v) : NW'(v);
  endfunction

  logic v4_q, v5_q, rdy4, rdy5;
  loc_e lp, lq, la, lb;
  logic shared;
  kind_e kind;
  logic [NW-1:0] un, ud;

  ctrl_t                ctrl4_q, ctrl5_q;
  logic signed [CB-1:0] ax4_q, ay4_q, ax5_q, ay5_q;
  logic [MW-1:0]        umx4_q, umy4_q;
  logic [NW-1:0]        un4_q, ud4_q, ud5_q;
  logic [PW-1:0]        px5_q, py5_q;

  assign rdy5    = !v5_q || ready_i;
  assign rdy4    = !v4_q || rdy5;
  assign ready_o = rdy4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy4) v4_q <= valid_i;
      if (rdy5) v5_q <= v4_q;
    end
  end

  always_comb begin
    lp = locate(eq_i.pa, eq_i.pb, cr_i[CR_DETP], ds_i[DS_PA], ds_i[DS_BP], ds_i[DS_AB]);
    lq = locate(eq_i.qa, eq_i.qb, cr_i[CR_DETQ], ds_i[DS_QA], ds_i[DS_BQ], ds_i[DS_AB]);
    la = locate(eq_i.pa, eq_i.qa, cr_i[CR_NUM], ds_i[DS_PA], ds_i[DS_QA], ds_i[DS_PQ]);
    lb = locate(eq_i.pb, eq_i.qb, cr_i[CR_DETB], ds_i[DS_BP], ds_i[DS_BQ], ds_i[DS_PQ]);
    shared = eq_i.pa | eq_i.qa | eq_i.pb | eq_i.qb;
    if ((cr_i[CR_DEN] == '0) || shared) begin
      // parallel or touching: edge when colinear and pq is longer
      kind = ((cr_i[CR_K4] == '0) && (ds_i[DS_PQ] > ds_i[DS_AB])) ? KIND_EDGE : KIND_NONE;
    end else if (!same_side(lp, lq) && !same_side(la, lb) && (lp != LOC_IN) &&
                 (lq != LOC_IN) && (la != LOC_IN) && (lb != LOC_IN)) begin
      kind = KIND_REGULAR;
    end else if (la == LOC_IN) begin
      kind = KIND_A_ON_PQ;
    end else if (lb == LOC_IN) begin
      kind = KIND_B_ON_PQ;
    end else begin
      kind = KIND_NONE;
    end
    ud = mag(cr_i[CR_DEN]);
    un = mag(cr_i[CR_NUM]);
    if (un > ud) un = ud;
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && valid_i) begin
      ctrl4_q.kind  <= kind;
      ctrl4_q.neg_x <= abx_i[MW-1] ^ cr_i[CR_NUM][NW-1] ^ cr_i[CR_DEN][NW-1];
      ctrl4_q.neg_y <= aby_i[MW-1] ^ cr_i[CR_NUM][NW-1] ^ cr_i[CR_DEN][NW-1];
      umx4_q <= abx_i[MW-1] ? MW'(-abx_i) : MW'(abx_i);
      umy4_q <= aby_i[MW-1] ? MW'(-aby_i) : MW'(aby_i);
      un4_q  <= un;
      ud4_q  <= ud;
      ax4_q  <= ax_i;
      ay4_q  <= ay_i;
    end
  end

  // dividend products |ab| * |num|
  always_ff @(posedge clk_i) begin
    if (rdy5 && v4_q) begin
      px5_q   <= PW'(umx4_q) * PW'(un4_q);
      py5_q   <= PW'(umy4_q) * PW'(un4_q);
      ud5_q   <= ud4_q;
      ctrl5_q <= ctrl4_q;
      ax5_q   <= ax4_q;
      ay5_q   <= ay4_q;
    end
  end

  assign valid_o  = v5_q;
  assign ctrl_o   = ctrl5_q;
  assign ax_o     = ax5_q;
  assign ay_o     = ay5_q;
  assign ud_o     = ud5_q;
  assign prod_x_o = px5_q;
  assign prod_y_o = py5_q;

endmodule

FILE: sv/sic_div_step.sv
// ---------------------------------------------------------------------------
// sic_div_step
// one restoring division step for both coordinates, registered
// ---------------------------------------------------------------------------
module sic_div_step #(
  parameter int CB = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  sic_pkg::ctrl_t        ctrl_i,
  input  logic signed [CB-1:0]  ax_i,
  input  logic signed [CB-1:0]  ay_i,
  input  logic [2*CB+1:0]       ud_i,
  input  logic [2*CB+1:0]       rx_i,
  input  logic [CB:0]           lx_i,
  input  logic [2*CB+1:0]       ry_i,
  input  logic [CB:0]           ly_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output sic_pkg::ctrl_t        ctrl_o,
  output logic signed [CB-1:0]  ax_o,
  output logic signed [CB-1:0]  ay_o,
  output logic [2*CB+1:0]       ud_o,
  output logic [2*CB+1:0]       rx_o,
  output logic [CB:0]           lx_o,
  output logic [2*CB+1:0]       ry_o,
  output logic [CB:0]           ly_o
);
  import sic_pkg::*;

  localparam int MW = CB + 1;
  localparam int NW = 2 * CB + 2;

  logic v_q;
  logic [NW:0] tx, ty;
  logic gx, gy;

  ctrl_t                ctrl_q;
  logic signed [CB-1:0] ax_q, ay_q;
  logic [NW-1:0]        ud_q, rx_q, ry_q;
  logic [MW-1:0]        lx_q, ly_q;

  assign ready_o = !v_q || ready_i;

  // shift in the next dividend bit, subtract when it fits
  assign tx = {rx_i, lx_i[MW-1]};
  assign ty = {ry_i, ly_i[MW-1]};
  assign gx = tx >= {1'b0, ud_i};
  assign gy = ty >= {1'b0, ud_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rx_q   <= gx ? NW'(tx - {1'b0, ud_i}) : NW'(tx);
      ry_q   <= gy ? NW'(ty - {1'b0, ud_i}) : NW'(ty);
      lx_q   <= {lx_i[MW-2:0], gx};
      ly_q   <= {ly_i[MW-2:0], gy};
      ud_q   <= ud_i;
      ctrl_q <= ctrl_i;
      ax_q   <= ax_i;
      ay_q   <= ay_i;
    end
  end

  assign valid_o = v_q;
  assign ctrl_o  = ctrl_q;
  assign ax_o    = ax_q;
  assign ay_o    = ay_q;
  assign ud_o    = ud_q;
  assign rx_o    = rx_q;
  assign lx_o    = lx_q;
  assign ry_o    = ry_q;
  assign ly_o    = ly_q;

endmodule

FILE: sv/segment_intersection_classify_unit.sv
// ---------------------------------------------------------------------------
// segment_intersection_classify_unit
// classifies how segment pq meets segment ab and gives the crossing point
// ---------------------------------------------------------------------------
//  channel  | dir | fields (lowest bit up)
//  s_axis   | in  | tdata: ax, ay, bx, by_coord, px, py, qx, qy (COORD_BITS each)
//  m_axis   | out | tuser: kind (3); tdata: cross_x, cross_y (COORD_BITS each), zero pad
//
//  stages: three front stages, two classify stages, one restoring divider
//  step per quotient bit (COORD_BITS + 1), a rounding stage and the output
//  register. one beat enters every cycle unless the pipeline is full and stalled.
//  reset clears only the valid bits of the stages.
//  each stage holds while its successor is full and stalled, so empty
//  stages keep filling while the output beat waits.
// ---------------------------------------------------------------------------
module segment_intersection_classify_unit #(
  parameter int COORD_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // ax, ay, bx, by_coord, px, py, qx, qy
  input  logic [8*COORD_BITS-1:0]              s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // cross_x, cross_y, zero pad
  output logic [((2*COORD_BITS+7)/8)*8-1:0]    m_axis_tdata,
  // kind
  output logic [2:0]                           m_axis_tuser
);
  import sic_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int MW = CB + 1;        // quotient bits
  localparam int NW = 2 * CB + 2;    // cross product bits
  localparam int PW = MW + NW;       // dividend bits
  localparam int OW = ((2 * CB + 7) / 8) * 8;

  // front to classify
  logic                 f_valid, f_ready;
  eq_t                  f_eq;
  logic signed [CB-1:0] f_ax, f_ay;
  logic signed [CB:0]   f_abx, f_aby;
  logic signed [NW-1:0] f_cr [6];
  logic [NW-1:0]        f_ds [6];

  // classify to divider
  logic                 c_valid, c_ready;
  ctrl_t                c_ctrl;
  logic signed [CB-1:0] c_ax, c_ay;
  logic [NW-1:0]        c_ud;
  logic [PW-1:0]        c_px, c_py;

  // divider chain
  logic                 dv_valid [MW+1];
  logic                 dv_ready [MW+1];
  ctrl_t                dv_ctrl  [MW+1];
  logic signed [CB-1:0] dv_ax    [MW+1];
  logic signed [CB-1:0] dv_ay    [MW+1];
  logic [NW-1:0]        dv_ud    [MW+1];
  logic [NW-1:0]        dv_rx    [MW+1];
  logic [MW-1:0]        dv_lx    [MW+1];
  logic [NW-1:0]        dv_ry    [MW+1];
  logic [MW-1:0]        dv_ly    [MW+1];

  // rounding and output stages
  logic                 rnd_v_q, out_v_q, rnd_rdy, out_rdy;
  ctrl_t                rnd_ctrl_q;
  logic signed [CB-1:0] rnd_ax_q, rnd_ay_q;
  logic [MW-1:0]        rnd_qx_q, rnd_qy_q;
  logic signed [MW:0]   off_x, off_y, sum_x, sum_y;
  kind_e                out_kind_q;
  logic [CB-1:0]        out_x_q, out_y_q;

  sic_front #(.CB(CB)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .ax_i    (s_axis_tdata[0*CB +: CB]),
    .ay_i    (s_axis_tdata[1*CB +: CB]),
    .bx_i    (s_axis_tdata[2*CB +: CB]),
    .by_i    (s_axis_tdata[3*CB +: CB]),
    .px_i    (s_axis_tdata[4*CB +: CB]),
    .py_i    (s_axis_tdata[5*CB +: CB]),
    .qx_i    (s_axis_tdata[6*CB +: CB]),
    .qy_i    (s_axis_tdata[7*CB +: CB]),
    .valid_o (f_valid),
    .ready_i (f_ready),
    .eq_o    (f_eq),
    .ax_o    (f_ax),
    .ay_o    (f_ay),
    .abx_o   (f_abx),
    .aby_o   (f_aby),
    .cr_o    (f_cr),
    .ds_o    (f_ds)
  );

  sic_classify #(.CB(CB)) u_classify (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (f_valid),
    .ready_o  (f_ready),
    .eq_i     (f_eq),
    .ax_i     (f_ax),
    .ay_i     (f_ay),
    .abx_i    (f_abx),
    .aby_i    (f_aby),
    .cr_i     (f_cr),
    .ds_i     (f_ds),
    .valid_o  (c_valid),
    .ready_i  (c_ready),
    .ctrl_o   (c_ctrl),
    .ax_o     (c_ax),
    .ay_o     (c_ay),
    .ud_o     (c_ud),
    .prod_x_o (c_px),
    .prod_y_o (c_py)
  );

  // the upper dividend part is already below the divisor, so the
  // quotient fits in MW bits
  assign dv_valid[0] = c_valid;
  assign c_ready     = dv_ready[0];
  assign dv_ctrl[0]  = c_ctrl;
  assign dv_ax[0]    = c_ax;
  assign dv_ay[0]    = c_ay;
  assign dv_ud[0]    = c_ud;
  assign dv_rx[0]    = c_px[PW-1:MW];
  assign dv_lx[0]    = c_px[MW-1:0];
  assign dv_ry[0]    = c_py[PW-1:MW];
  assign dv_ly[0]    = c_py[MW-1:0];

  for (genvar i = 0; i < MW; i++) begin : g_div
    sic_div_step #(.CB(CB)) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv_valid[i]),
      .ready_o (dv_ready[i]),
      .ctrl_i  (dv_ctrl[i]),
      .ax_i    (dv_ax[i]),
      .ay_i    (dv_ay[i]),
      .ud_i    (dv_ud[i]),
      .rx_i    (dv_rx[i]),
      .lx_i    (dv_lx[i]),
      .ry_i    (dv_ry[i]),
      .ly_i    (dv_ly[i]),
      .valid_o (dv_valid[i+1]),
      .ready_i (dv_ready[i+1]),
      .ctrl_o  (dv_ctrl[i+1]),
      .ax_o    (dv_ax[i+1]),
      .ay_o    (dv_ay[i+1]),
      .ud_o    (dv_ud[i+1]),
      .rx_o    (dv_rx[i+1]),
      .lx_o    (dv_lx[i+1]),
      .ry_o    (dv_ry[i+1]),
      .ly_o    (dv_ly[i+1])
    );
  end

  assign out_rdy      = !out_v_q || m_axis_tready;
  assign rnd_rdy      = !rnd_v_q || out_rdy;
  assign dv_ready[MW] = rnd_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (rnd_rdy) rnd_v_q <= dv_valid[MW];
      if (out_rdy) out_v_q <= rnd_v_q;
    end
  end

  // round half away from zero: bump the magnitude when 2r >= d
  always_ff @(posedge clk_i) begin
    if (rnd_rdy && dv_valid[MW]) begin
      rnd_qx_q   <= dv_lx[MW] + MW'({dv_rx[MW], 1'b0} >= {1'b0, dv_ud[MW]});
      rnd_qy_q   <= dv_ly[MW] + MW'({dv_ry[MW], 1'b0} >= {1'b0, dv_ud[MW]});
      rnd_ctrl_q <= dv_ctrl[MW];
      rnd_ax_q   <= dv_ax[MW];
      rnd_ay_q   <= dv_ay[MW];
    end
  end

  // apply sign and add to a; the result wraps to the coordinate width
  always_comb begin
    off_x = rnd_ctrl_q.neg_x ? -$signed({1'b0, rnd_qx_q}) : $signed({1'b0, rnd_qx_q});
    off_y = rnd_ctrl_q.neg_y ? -$signed({1'b0, rnd_qy_q}) : $signed({1'b0, rnd_qy_q});
    sum_x = (MW+1)'(rnd_ax_q) + off_x;
    sum_y = (MW+1)'(rnd_ay_q) + off_y;
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && rnd_v_q) begin
      out_kind_q <= rnd_ctrl_q.kind;
      if (rnd_ctrl_q.kind == KIND_REGULAR) begin
        out_x_q <= sum_x[CB-1:0];
        out_y_q <= sum_y[CB-1:0];
      end else begin
        out_x_q <= '1;
        out_y_q <= '1;
      end
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = OW'({out_y_q, out_x_q});
  assign m_axis_tuser  = out_kind_q;

endmodule

FILE: tb/sv/segment_intersection_classify_unit_test.sv
// ---------------------------------------------------------------------------
// segment_intersection_classify_unit_test
// self-checking bench for the segment pair classifier: directed table of
// corner cases, then random segment pairs, every result checked in order
// against the table entry or a local integer predictor, with random idling on both sides
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module segment_intersection_classify_unit_test;
  import sic_pkg::*;

  localparam int CB       = 16;
  localparam int OUT_W    = ((2*CB+7)/8)*8;
  localparam int N_RANDOM = 1750;
  localparam int WD_LIMIT = 20000;
  localparam int DRAIN    = CB + 40;

  typedef struct packed {
    logic signed [CB-1:0] qy, qx, py, px, by_coord, bx, ay, ax;
  } seg_pair_t;

  typedef struct packed {
    logic signed [CB-1:0] cross_y, cross_x;
    kind_e                kind;
  } seg_class_t;

  // directed row: expected result typed in only where obvious
  typedef struct {
    seg_pair_t  pair;
    logic       has_exp;
    seg_class_t exp;
  } stim_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [8*CB-1:0]  s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic [2:0]       m_axis_tuser;

  seg_class_t class_queue[$];
  stim_row_t  rows[$];
  int         mismatch_count = 0;
  int         idle_cycles = 0;
  bit         stim_done = 1'b0;
  bit         hold_off = 1'b0;
  bit         no_idle = 1'b0;

  always #2 clk_i = ~clk_i;

  segment_intersection_classify_unit #(.COORD_BITS(CB)) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // ax, ay, bx, by_coord, px, py, qx, qy
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // cross_x, cross_y, zero pad
    .m_axis_tuser (m_axis_tuser)    // kind
  );

  // ---------------- predictor ----------------

  function automatic longint cross_prod(longint ux, longint uy, longint vx, longint vy);
    return ux * vy - uy * vx;
  endfunction

  function automatic longint sq_len(longint x0, longint y0, longint x1, longint y1);
    return (x1 - x0) * (x1 - x0) + (y1 - y0) * (y1 - y0);
  endfunction

  function automatic loc_e place_point(longint x0, longint y0, longint x1, longint y1,
                                       longint x, longint y);
    longint det, len;
    if (x == x0 && y == y0) return LOC_A;
    if (x == x1 && y == y1) return LOC_B;
    det = cross_prod(x1 - x0, y1 - y0, x - x0, y - y0);
    if (det == 0) begin
      len = sq_len(x0, y0, x1, y1);
      if (sq_len(x0, y0, x, y) < len && sq_len(x1, y1, x, y) < len) return LOC_IN;
      return LOC_OUT;
    end
    return (det > 0) ? LOC_LEFT : LOC_RIGHT;
  endfunction

  function automatic bit one_side(loc_e l1, loc_e l2);
    return l1 == l2 && (l1 == LOC_LEFT || l1 == LOC_RIGHT);
  endfunction

  // m * n / d rounded half away from zero, n clamped to |d|
  function automatic longint scaled_offset(longint m, longint n, longint d);
    longint um, un, ud, q, r;
    bit neg;
    neg = ((m < 0) != (n < 0)) != (d < 0);
    um = (m < 0) ? -m : m;
    un = (n < 0) ? -n : n;
    ud = (d < 0) ? -d : d;
    if (ud == 0) return 0;
    if (un > ud) un = ud;
    q = (um * un) / ud;
    r = (um * un) % ud;
    if (2 * r >= ud) q++;
    return neg ? -q : q;
  endfunction

  function automatic seg_class_t classify_pair(seg_pair_t s);
    seg_class_t res;
    longint ax, ay, bx, by, px, py, qx, qy, abx, aby, pqx, pqy, num, den;
    loc_e lp, lq, la, lb;
    bit shared;
    ax = s.ax; ay = s.ay; bx = s.bx; by = s.by_coord;
    px = s.px; py = s.py; qx = s.qx; qy = s.qy;
    abx = bx - ax; aby = by - ay; pqx = qx - px; pqy = qy - py;
    res.kind = KIND_NONE;
    res.cross_x = '1;
    res.cross_y = '1;
    shared = (ax == px && ay == py) || (ax == qx && ay == qy) ||
             (bx == px && by == py) || (bx == qx && by == qy);
    den = cross_prod(abx, aby, pqx, pqy);
    if (den == 0 || shared) begin
      if (cross_prod(px - ax, py - ay, qx - ax, qy - ay) == 0 &&
          sq_len(px, py, qx, qy) > sq_len(ax, ay, bx, by))
        res.kind = KIND_EDGE;
    end else begin
      lp = place_point(ax, ay, bx, by, px, py);
      lq = place_point(ax, ay, bx, by, qx, qy);
      la = place_point(px, py, qx, qy, ax, ay);
      lb = place_point(px, py, qx, qy, bx, by);
      if (!one_side(lp, lq) && !one_side(la, lb) && lp != LOC_IN && lq != LOC_IN &&
          la != LOC_IN && lb != LOC_IN) begin
        num = cross_prod(px - ax, py - ay, pqx, pqy);
        res.kind = KIND_REGULAR;
        res.cross_x = CB'(ax + scaled_offset(abx, num, den));
        res.cross_y = CB'(ay + scaled_offset(aby, num, den));
      end else if (la == LOC_IN) begin
        res.kind = KIND_A_ON_PQ;
      end else if (lb == LOC_IN) begin
        res.kind = KIND_B_ON_PQ;
      end
    end
    return res;
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic seg_pair_t mk_pair(int ax, int ay, int bx, int by, int px, int py,
                                        int qx, int qy);
    seg_pair_t s;
    s.ax = CB'(ax); s.ay = CB'(ay); s.bx = CB'(bx); s.by_coord = CB'(by);
    s.px = CB'(px); s.py = CB'(py); s.qx = CB'(qx); s.qy = CB'(qy);
    return s;
  endfunction

  function automatic seg_class_t mk_class(kind_e k, int x, int y);
    seg_class_t c;
    c.kind = k; c.cross_x = CB'(x); c.cross_y = CB'(y);
    return c;
  endfunction

  task automatic add_row(seg_pair_t s, bit has_exp, seg_class_t e);
    stim_row_t r;
    r.pair = s; r.has_exp = has_exp; r.exp = e;
    rows.insert(rows.size(), r);
  endtask

  function automatic int rand_coord(int span);
    if (span == 0) return $signed(16'($urandom));
    return $urandom_range(2*span) - span;
  endfunction

  // random pair: mostly small crossings, with colinear, shared and full range mixes
  function automatic seg_pair_t rand_pair();
    seg_pair_t s;
    int span, mode, t;
    span = ($urandom_range(3) == 0) ? 0 : (1 << $urandom_range(2, 12));
    mode = $urandom_range(9);
    s = mk_pair(rand_coord(span), rand_coord(span), rand_coord(span), rand_coord(span),
                rand_coord(span), rand_coord(span), rand_coord(span), rand_coord(span));
    case (mode)
      0: begin  // pq through a: a inside pq
        t = $urandom_range(1, 5);
        s.qx = CB'(s.ax + (s.ax - s.px) / t);
        s.qy = CB'(s.ay + (s.ay - s.py) / t);
        if (t == 1) begin s.qx = CB'(2*s.ax - s.px); s.qy = CB'(2*s.ay - s.py); end
      end
      1: begin  // b midway on pq
        s.qx = CB'(2*s.bx - s.px); s.qy = CB'(2*s.by_coord - s.py);
      end
      2: begin  // colinear pq along ab
        t = $urandom_range(4) - 2;
        s.px = CB'(s.ax + t * (s.bx - s.ax)); s.py = CB'(s.ay + t * (s.by_coord - s.ay));
        t = $urandom_range(6) - 3;
        s.qx = CB'(s.ax + t * (s.bx - s.ax)); s.qy = CB'(s.ay + t * (s.by_coord - s.ay));
      end
      3: begin  // shared end point
        if ($urandom_range(1)) begin s.px = s.bx; s.py = s.by_coord; end
        else begin s.qx = s.ax; s.qy = s.ay; end
      end
      4: begin  // degenerate ab
        s.bx = s.ax; s.by_coord = s.ay;
      end
      default: begin  // symmetric crossing around a common center
        s.px = CB'(-s.qx + 2*(s.ax + s.bx)/2 + $urandom_range(2) - 1);
        s.py = CB'(-s.qy + 2*(s.ay + s.by_coord)/2 + $urandom_range(2) - 1);
      end
    endcase
    return s;
  endfunction

  task automatic send_pair(seg_pair_t s);
    if (!no_idle) begin
      while ($urandom_range(99) < 11) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= s;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // ---------------- sender ----------------

  initial begin
    int i;
    seg_pair_t s;
    add_row(mk_pair(0, 0, 0, 0, 0, 0, 0, 0), 1, mk_class(KIND_NONE, -1, -1));
    add_row(mk_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768), 0, '0);
    add_row(mk_pair(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767), 0, '0);
    add_row(mk_pair(-4, 0, 4, 0, 0, -4, 0, 4), 1, mk_class(KIND_REGULAR, 0, 0));
    add_row(mk_pair(0, 0, 4, 0, 2, -2, 2, 2), 1, mk_class(KIND_REGULAR, 2, 0));
    add_row(mk_pair(0, 0, 3, 1, 1, -5, 2, 6), 0, '0);
    add_row(mk_pair(0, 0, 1, 0, 5, 5, 6, 6), 1, mk_class(KIND_NONE, -1, -1));
    add_row(mk_pair(0, 0, 2, 0, -4, 0, 4, 0), 1, mk_class(KIND_EDGE, -1, -1));
    add_row(mk_pair(-4, 0, 4, 0, -1, 0, 1, 0), 1, mk_class(KIND_NONE, -1, -1));
    add_row(mk_pair(0, 0, 2, 0, 0, 0, 0, 5), 1, mk_class(KIND_EDGE, -1, -1));
    add_row(mk_pair(0, 0, 1, 0, 0, 0, 0, 5), 1, mk_class(KIND_EDGE, -1, -1));
    add_row(mk_pair(0, 0, 0, 5, 0, 0, 3, 0), 1, mk_class(KIND_NONE, -1, -1));
    add_row(mk_pair(0, 0, 4, 4, -1, 0, 1, 0), 1, mk_class(KIND_A_ON_PQ, -1, -1));
    add_row(mk_pair(4, 4, 0, 0, -1, 0, 1, 0), 1, mk_class(KIND_B_ON_PQ, -1, -1));
    add_row(mk_pair(0, 0, 4, 0, 4, -1, 4, 1), 0, '0);
    add_row(mk_pair(0, 0, 4, 0, 1, 0, 1, 5), 0, '0);
    add_row(mk_pair(3, 3, 3, 3, -5, 3, 9, 3), 0, '0);
    add_row(mk_pair(3, 3, 3, 3, 0, 0, 1, 1), 0, '0);
    add_row(mk_pair(0, 0, 3, 0, 1, -1, 2, 1), 0, '0);
    add_row(mk_pair(0, 0, -3, 0, -1, -1, -2, 1), 0, '0);
    add_row(mk_pair(-32768, 0, 32767, 0, 0, -32768, 1, 32767), 0, '0);
    add_row(mk_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767), 0, '0);
    add_row(mk_pair(-1, -1, -1, -1, -1, -1, -1, -1), 1, mk_class(KIND_NONE, -1, -1));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[k]) begin
      if (rows[k].has_exp && classify_pair(rows[k].pair) !== rows[k].exp)
        $display("directed row %0d: table and predictor disagree", k);
      class_queue.insert(class_queue.size(),
                         rows[k].has_exp ? rows[k].exp : classify_pair(rows[k].pair));
      send_pair(rows[k].pair);
    end
    for (i = 0; i < N_RANDOM; i++) begin
      if (i == 400) no_idle = 1'b1;
      if (i == 700) no_idle = 1'b0;
      if (i == 900) hold_off = 1'b1;
      s = rand_pair();
      class_queue.insert(class_queue.size(), classify_pair(s));
      send_pair(s);
    end
    s_axis_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  // ---------------- receiver ----------------

  // idles at random; one long hold-off fills the pipeline
  always @(posedge clk_i) begin
    if (hold_off) begin
      m_axis_tready <= 1'b0;
      repeat (3 * CB + 60) @(posedge clk_i);
      hold_off = 1'b0;
    end else begin
      m_axis_tready <= no_idle || ($urandom_range(99) >= 11);
    end
  end

  // ---------------- checker ----------------

  always @(posedge clk_i) begin
    seg_class_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[2*CB-1:0], m_axis_tuser};
      if (class_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result beat: %p", got);
      end else begin
        want = class_queue.pop_front();
        if (got.kind !== want.kind || got.cross_x !== want.cross_x ||
            got.cross_y !== want.cross_y) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected kind %0d (%0d,%0d), got kind %0d (%0d,%0d)",
                     want.kind, want.cross_x, want.cross_y,
                     got.kind, got.cross_x, got.cross_y);
        end
      end
    end
  end

  // watchdog: cycles with no beat accepted on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------- end of run ----------------

  initial begin
    wait (stim_done);
    while (class_queue.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (mismatch_count == 0 && class_queue.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
